FILE: design/pwbs_pkg.sv
// Shared types and segment-table functions for the pixel window boundary segment block.
package pwbs_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int COLOUR_BITS = 24;
   localparam int ROW_W       = 12;
   localparam int COL_W       = 12;
   localparam int COLOUR_W    = 24;
   localparam int COORD_W     = 15;
   localparam int DIM_W       = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int OFF_W       = 3;
   localparam int MAX_SEGS    = 6;
   localparam int SEG_CNT_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS    = 1'd1;

   localparam logic [COORD_W-1:0] LIM_RESET = COORD_W'(6 * 256);

   typedef struct packed {
      logic [ROW_W-1:0]    window_row;
      logic [COL_W-1:0]    window_col;
      logic [COLOUR_W-1:0] colour_top_left;
      logic [COLOUR_W-1:0] colour_top_right;
      logic [COLOUR_W-1:0] colour_bottom_left;
      logic [COLOUR_W-1:0] colour_bottom_right;
   } req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               last_segment;
   } rsp_item_type;

   // corner of the window: bx/by set means +6 sixths in x/y
   typedef struct packed {
      logic bx;
      logic by;
   } corner_type;

   // segment endpoints as offsets in sixths from the top-left pixel centre
   typedef struct packed {
      logic [OFF_W-1:0] sx;
      logic [OFF_W-1:0] sy;
      logic [OFF_W-1:0] ex;
      logic [OFF_W-1:0] ey;
   } seg_type;

   typedef struct packed {
      logic [1:0]        count;
      seg_type [2:0]     segs;
   } tri_segs_type;

   typedef struct packed {
      logic [COORD_W-1:0]   base_x;
      logic [COORD_W-1:0]   base_y;
      logic [SEG_CNT_W-1:0] count;
      seg_type [MAX_SEGS-1:0] segs;
   } entry_type;

   typedef enum logic [2:0] {
      TRI_NONE,
      TRI_ALL,
      TRI_C01,
      TRI_C12,
      TRI_C02
   } tri_class_type;

   localparam corner_type CORNER_TL = '{bx: 1'b0, by: 1'b0};
   localparam corner_type CORNER_TR = '{bx: 1'b1, by: 1'b0};
   localparam corner_type CORNER_BL = '{bx: 1'b0, by: 1'b1};
   localparam corner_type CORNER_BR = '{bx: 1'b1, by: 1'b1};

   function automatic tri_class_type tri_class(input logic [COLOUR_BITS-1:0] c0,
                                               input logic [COLOUR_BITS-1:0] c1,
                                               input logic [COLOUR_BITS-1:0] c2);
      tri_class_type cls;
      if (c0 != c1 && c0 != c2 && c1 != c2) begin
         cls = TRI_ALL;
      end else if (c0 == c1 && c0 != c2) begin
         cls = TRI_C01;
      end else if (c1 == c2 && c0 != c2) begin
         cls = TRI_C12;
      end else if (c0 == c2 && c1 != c2) begin
         cls = TRI_C02;
      end else begin
         cls = TRI_NONE;
      end
      return cls;
   endfunction

   function automatic logic [OFF_W-1:0] mid_off(input logic a, input logic b);
      logic [1:0] s;
      s = {1'b0, a} + {1'b0, b};
      return {s, 1'b0} + {1'b0, s};
   endfunction

   function automatic logic [OFF_W-1:0] cen_off(input logic a, input logic b, input logic c);
      logic [1:0] s;
      s = {1'b0, a} + {1'b0, b} + {1'b0, c};
      return {s, 1'b0};
   endfunction

   function automatic seg_type make_seg(input logic [OFF_W-1:0] sx, input logic [OFF_W-1:0] sy,
                                        input logic [OFF_W-1:0] ex, input logic [OFF_W-1:0] ey);
      seg_type s;
      s.sx = sx;
      s.sy = sy;
      s.ex = ex;
      s.ey = ey;
      return s;
   endfunction

   function automatic tri_segs_type tri_segs(input corner_type p0, input corner_type p1,
                                             input corner_type p2, input tri_class_type cls);
      tri_segs_type t;
      logic [OFF_W-1:0] m01x, m01y, m12x, m12y, m02x, m02y, cx, cy;
      m01x = mid_off(p0.bx, p1.bx);
      m01y = mid_off(p0.by, p1.by);
      m12x = mid_off(p1.bx, p2.bx);
      m12y = mid_off(p1.by, p2.by);
      m02x = mid_off(p0.bx, p2.bx);
      m02y = mid_off(p0.by, p2.by);
      cx   = cen_off(p0.bx, p1.bx, p2.bx);
      cy   = cen_off(p0.by, p1.by, p2.by);
      t = '0;
      case (cls)
         TRI_ALL: begin
            t.count   = 2'd3;
            t.segs[0] = make_seg(m12x, m12y, cx, cy);
            t.segs[1] = make_seg(m01x, m01y, cx, cy);
            t.segs[2] = make_seg(m02x, m02y, cx, cy);
         end
         TRI_C01: begin
            t.count   = 2'd1;
            t.segs[0] = make_seg(m02x, m02y, m12x, m12y);
         end
         TRI_C12: begin
            t.count   = 2'd1;
            t.segs[0] = make_seg(m01x, m01y, m02x, m02y);
         end
         TRI_C02: begin
            t.count   = 2'd1;
            t.segs[0] = make_seg(m12x, m12y, m01x, m01y);
         end
         default: begin
            t.count = 2'd0;
         end
      endcase
      return t;
   endfunction

endpackage

FILE: design/pwbs_front.sv
// Front end: splits a window into triangles and builds its segment list.
module pwbs_front (
   input  pwbs_pkg::req_item_type req_item,
   output pwbs_pkg::entry_type    entry,
   output logic                   has_segs
);
   import pwbs_pkg::*;

   logic [COLOUR_BITS-1:0] ctl, ctr, cbl, cbr;
   logic [COORD_W-1:0]     col6, row6;
   tri_segs_type           tri_a, tri_b;
   logic [SEG_CNT_W-1:0]   n_a, n_b, kk, jj;

   always_comb begin
      ctl = req_item.colour_top_left[COLOUR_BITS-1:0];
      ctr = req_item.colour_top_right[COLOUR_BITS-1:0];
      cbl = req_item.colour_bottom_left[COLOUR_BITS-1:0];
      cbr = req_item.colour_bottom_right[COLOUR_BITS-1:0];

      if (ctl != cbr) begin
         tri_a = tri_segs(CORNER_TL, CORNER_TR, CORNER_BL, tri_class(ctl, ctr, cbl));
         tri_b = tri_segs(CORNER_BR, CORNER_TR, CORNER_BL, tri_class(cbr, ctr, cbl));
      end else begin
         tri_a = tri_segs(CORNER_TL, CORNER_BR, CORNER_BL, tri_class(ctl, cbr, cbl));
         tri_b = tri_segs(CORNER_TL, CORNER_BR, CORNER_TR, tri_class(ctl, cbr, ctr));
      end

      n_a = {1'b0, tri_a.count};
      n_b = {1'b0, tri_b.count};

      col6 = {1'b0, req_item.window_col, 2'b00} + {2'b00, req_item.window_col, 1'b0};
      row6 = {1'b0, req_item.window_row, 2'b00} + {2'b00, req_item.window_row, 1'b0};

      entry.base_x = col6 + COORD_W'(3);
      entry.base_y = row6 + COORD_W'(3);
      entry.count  = n_a + n_b;
      for (int k = 0; k < MAX_SEGS; k++) begin
         kk = SEG_CNT_W'(k);
         jj = kk - n_a;
         if (kk < n_a) begin
            entry.segs[k] = tri_a.segs[kk[1:0]];
         end else if (jj < n_b) begin
            entry.segs[k] = tri_b.segs[jj[1:0]];
         end else begin
            entry.segs[k] = '0;
         end
      end
      has_segs = (entry.count != '0);
   end

endmodule

FILE: design/pwbs_queue.sv
// Short queue of classified windows between front and back.
module pwbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pwbs_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pwbs_pkg::entry_type pop_data
);
   import pwbs_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         fill_ff, fill_in;
   logic                    do_push, do_pop;

   always_comb begin
      push_ready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
      pop_valid  = (fill_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in    = fill_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/pwbs_back.sv
// Back end: walks one window's segments, adds offsets, wraps, drives the result register.
module pwbs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pwbs_pkg::COORD_W-1:0] lim_x,
   input  logic [pwbs_pkg::COORD_W-1:0] lim_y,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  pwbs_pkg::entry_type        pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pwbs_pkg::rsp_item_type     rsp_item
);
   import pwbs_pkg::*;

   entry_type            cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [SEG_CNT_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                 out_free, emit, last, load;
   seg_type              seg;

   function automatic logic [COORD_W-1:0] wrap(input logic [COORD_W-1:0] base,
                                              input logic [OFF_W-1:0]   off,
                                              input logic [COORD_W-1:0] lim);
      logic [COORD_W-1:0] v;
      v = base + {{(COORD_W-OFF_W){1'b0}}, off};
      if (v > lim) begin
         v = v - lim;
      end
      return v;
   endfunction

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = cur_valid_ff && out_free;
      last      = (idx_ff == cur_ff.count - 1'b1);
      pop_ready = !cur_valid_ff || (emit && last);
      load      = pop_ready && pop_valid;
      seg       = cur_ff.segs[idx_ff];

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = pop_data;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (emit && last) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.start_x      = wrap(cur_ff.base_x, seg.sx, lim_x);
         rsp_item_in.start_y      = wrap(cur_ff.base_y, seg.sy, lim_y);
         rsp_item_in.end_x        = wrap(cur_ff.base_x, seg.ex, lim_x);
         rsp_item_in.end_y        = wrap(cur_ff.base_y, seg.ey, lim_y);
         rsp_item_in.last_segment = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: design/pixel_window_boundary_segments_top.sv
// Top level: size registers, front end, window queue and back end.
//
// Each req item is a 2x2 window of colour labels with its row and column.
// The block returns 0 to 6 rsp items, one boundary segment each, in sixths
// of a pixel; last_segment marks the final segment of a window. A window
// with one colour everywhere yields no rsp item.
// The csr port sets image_columns (index 0) and image_rows (index 1), which
// fix the wrap points; values above 4096 are held at 4096. Write them only
// while the block is idle.
// The first segment of a window passes through the queue, the back end's
// current-window register and the output register.
// The back end gives one segment per cycle while the output is free;
// windows without segments are not queued. A four-entry queue lets the
// front keep accepting while the back is busy; req_ready drops only when
// the queue is full.
// Reset clears the queue and output register and sets both sizes to 256.
// When rsp_ready is low the rsp item holds and the back end waits; the
// queue then fills and req_ready follows.
module pixel_window_boundary_segments_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pwbs_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pwbs_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_write,
   input  logic [pwbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pwbs_pkg::DIM_W-1:0]       csr_data
);
   import pwbs_pkg::*;

   logic [COORD_W-1:0] lim_x_ff, lim_x_in, lim_y_ff, lim_y_in;
   logic [DIM_W-1:0]   dim_clamp;
   logic [COORD_W-1:0] lim_new;
   entry_type          front_entry, pop_data;
   logic               has_segs, push_ready, pop_valid, pop_ready;

   always_comb begin
      dim_clamp = (csr_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_data;
      lim_new   = {dim_clamp, 2'b00} + {1'b0, dim_clamp, 1'b0};
      lim_x_in  = lim_x_ff;
      lim_y_in  = lim_y_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_COLUMNS: lim_x_in = lim_new;
            CSR_IMAGE_ROWS:    lim_y_in = lim_new;
            default: begin
            end
         endcase
      end
      req_ready = push_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_x_ff <= LIM_RESET;
         lim_y_ff <= LIM_RESET;
      end else begin
         lim_x_ff <= lim_x_in;
         lim_y_ff <= lim_y_in;
      end
   end

   pwbs_front u_front (
      .req_item (req_item),
      .entry    (front_entry),
      .has_segs (has_segs)
   );

   pwbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid && has_segs),
      .push_ready (push_ready),
      .push_data  (front_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pwbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .lim_x     (lim_x_ff),
      .lim_y     (lim_y_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the pixel window boundary segment block.
module testbench;
   import pwbs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      int unsigned x;
      int unsigned y;
   } spot_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_item_type       req_item = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_COLUMNS;
   logic [DIM_W-1:0]   csr_data = '0;

   int unsigned cols_now = 256;
   int unsigned rows_now = 256;
   rsp_item_type segments_due[$];
   rsp_item_type window_segs[$];

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int windows_sent = 0;
   int segments_checked = 0;
   int size_settings = 0;
   int cycle_count = 0;

   pixel_window_boundary_segments_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d segments outstanding", cycle_count,
                  segments_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------- segment predictor ----------------

   function automatic spot_type halfway(input spot_type a, input spot_type b);
      spot_type m;
      m.x = (a.x + b.x) / 2;
      m.y = (a.y + b.y) / 2;
      return m;
   endfunction

   function automatic int unsigned wrap_sixths(input int unsigned v, input int unsigned dim);
      int unsigned span;
      span = 6 * dim;
      return (v > span) ? v - span : v;
   endfunction

   function automatic void add_segment(input spot_type a, input spot_type b);
      rsp_item_type s;
      s.start_x      = COORD_W'(wrap_sixths(a.x, cols_now));
      s.start_y      = COORD_W'(wrap_sixths(a.y, rows_now));
      s.end_x        = COORD_W'(wrap_sixths(b.x, cols_now));
      s.end_y        = COORD_W'(wrap_sixths(b.y, rows_now));
      s.last_segment = 1'b0;
      window_segs.push_back(s);
   endfunction

   function automatic void trace_triangle(input spot_type p0, input spot_type p1,
                                          input spot_type p2,
                                          input logic [COLOUR_BITS-1:0] c0,
                                          input logic [COLOUR_BITS-1:0] c1,
                                          input logic [COLOUR_BITS-1:0] c2);
      spot_type mid;
      mid.x = (p0.x + p1.x + p2.x) / 3;
      mid.y = (p0.y + p1.y + p2.y) / 3;
      if (c0 != c1 && c0 != c2 && c1 != c2) begin
         add_segment(halfway(p1, p2), mid);
         add_segment(halfway(p0, p1), mid);
         add_segment(halfway(p0, p2), mid);
      end else if (c0 == c1 && c0 != c2) begin
         add_segment(halfway(p0, p2), halfway(p2, p1));
      end else if (c1 == c2 && c0 != c2) begin
         add_segment(halfway(p0, p1), halfway(p0, p2));
      end else if (c0 == c2 && c1 != c2) begin
         add_segment(halfway(p1, p2), halfway(p0, p1));
      end
   endfunction

   function automatic void predict_segments(input req_item_type w);
      spot_type tl, tr, bl, br;
      rsp_item_type tail;
      window_segs = {};
      tl.x = 6 * w.window_col + 3;
      tl.y = 6 * w.window_row + 3;
      tr.x = tl.x + 6;
      tr.y = tl.y;
      bl.x = tl.x;
      bl.y = tl.y + 6;
      br.x = tl.x + 6;
      br.y = tl.y + 6;
      if (w.colour_top_left[COLOUR_BITS-1:0] != w.colour_bottom_right[COLOUR_BITS-1:0]) begin
         trace_triangle(tl, tr, bl, w.colour_top_left, w.colour_top_right,
                        w.colour_bottom_left);
         trace_triangle(br, tr, bl, w.colour_bottom_right, w.colour_top_right,
                        w.colour_bottom_left);
      end else begin
         trace_triangle(tl, br, bl, w.colour_top_left, w.colour_bottom_right,
                        w.colour_bottom_left);
         trace_triangle(tl, br, tr, w.colour_top_left, w.colour_bottom_right,
                        w.colour_top_right);
      end
      if (window_segs.size() > 0) begin
         tail = window_segs.pop_back();
         tail.last_segment = 1'b1;
         window_segs.push_back(tail);
      end
      foreach (window_segs[k]) segments_due.push_back(window_segs[k]);
   endfunction

   // ---------------- result checking ----------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (segments_due.size() == 0) begin
            $error("unexpected segment %p", rsp_item);
            fail_count++;
         end else begin
            want = segments_due.pop_front();
            check_field("start_x", want.start_x, rsp_item.start_x);
            check_field("start_y", want.start_y, rsp_item.start_y);
            check_field("end_x", want.end_x, rsp_item.end_x);
            check_field("end_y", want.end_y, rsp_item.end_y);
            check_field("last_segment", want.last_segment, rsp_item.last_segment);
            segments_checked++;
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_window(input req_item_type w);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < req_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= w;
      do @(posedge clock); while (!req_ready);
      predict_segments(w);
      windows_sent++;
   endtask

   task automatic drain_segments();
      req_valid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_image_size(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_COLUMNS;
      csr_data  <= cols;
      @(posedge clock);
      csr_index <= CSR_IMAGE_ROWS;
      csr_data  <= rows;
      @(posedge clock);
      csr_write <= 1'b0;
      cols_now = (cols > MAX_DIM) ? MAX_DIM : cols;
      rows_now = (rows > MAX_DIM) ? MAX_DIM : rows;
      size_settings++;
   endtask

   function automatic req_item_type window(input int unsigned row, input int unsigned col,
                                           input logic [COLOUR_W-1:0] tl,
                                           input logic [COLOUR_W-1:0] tr,
                                           input logic [COLOUR_W-1:0] bl,
                                           input logic [COLOUR_W-1:0] br);
      req_item_type w;
      w.window_row          = ROW_W'(row);
      w.window_col          = COL_W'(col);
      w.colour_top_left     = tl;
      w.colour_top_right    = tr;
      w.colour_bottom_left  = bl;
      w.colour_bottom_right = br;
      return w;
   endfunction

   // mostly at the wrap point or near zero, otherwise anywhere
   function automatic int unsigned pick_index(input int unsigned dim);
      int unsigned v;
      case ($urandom_range(3))
         0: v = $urandom_range(4095);
         1: v = dim - 1;
         2: v = dim;
         default: v = $urandom_range(7);
      endcase
      return v & 12'hFFF;
   endfunction

   function automatic req_item_type random_window();
      logic [COLOUR_W-1:0] shade [4];
      req_item_type w;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(3) == 0) shade[i] = $urandom_range(1) ? '1 : '0;
         else shade[i] = COLOUR_W'($urandom);
      end
      w = window(pick_index(rows_now), pick_index(cols_now),
                 shade[$urandom_range(3)], shade[$urandom_range(3)],
                 shade[$urandom_range(3)], shade[$urandom_range(3)]);
      if ($urandom_range(19) == 0) begin
         w.colour_top_right    = w.colour_top_left;
         w.colour_bottom_left  = w.colour_top_left;
         w.colour_bottom_right = w.colour_top_left;
      end else if ($urandom_range(9) == 0) begin
         w.colour_bottom_right = COLOUR_W'($urandom);
      end
      return w;
   endfunction

   // ---------------- tests ----------------

   localparam logic [COLOUR_W-1:0] CA = 24'h000000;
   localparam logic [COLOUR_W-1:0] CB = 24'hFFFFFF;
   localparam logic [COLOUR_W-1:0] CC = 24'h5A3C96;
   localparam logic [COLOUR_W-1:0] CD = 24'hA5C369;

   task automatic test_triangle_classes();
      send_window(window(10, 20, CA, CA, CA, CA));
      send_window(window(10, 20, CB, CB, CB, CB));
      send_window(window(10, 20, CA, CB, CC, CD));
      send_window(window(10, 20, CA, CA, CC, CD));
      send_window(window(10, 20, CA, CB, CB, CD));
      send_window(window(10, 20, CA, CB, CA, CD));
      send_window(window(10, 20, CA, CB, CC, CB));
      send_window(window(10, 20, CA, CB, CC, CC));
      send_window(window(10, 20, CA, CB, CC, CA));
      send_window(window(10, 20, CA, CA, CC, CA));
      send_window(window(10, 20, CA, CB, CA, CA));
      send_window(window(10, 20, CB, CA, CA, CB));
   endtask

   task automatic test_wrap_points();
      send_window(window(0, 0, CA, CB, CC, CD));
      send_window(window(255, 255, CA, CB, CC, CD));
      send_window(window(256, 256, CD, CC, CB, CA));
      send_window(window(4095, 4095, CA, CB, CC, CD));
      send_window(window(0, 4095, CB, CA, CD, CC));
      send_window(window(4095, 0, CC, CD, CA, CB));
   endtask

   task automatic test_size_registers();
      drain_segments();
      set_image_size(1, 1);
      send_window(window(0, 0, CA, CB, CC, CD));
      send_window(window(1, 2, CA, CB, CC, CD));
      drain_segments();
      set_image_size(4096, 4096);
      send_window(window(4095, 4095, CA, CB, CC, CD));
      send_window(window(4095, 0, CD, CB, CC, CA));
      drain_segments();
      set_image_size(8191, 5000);
      send_window(window(4095, 4095, CA, CB, CC, CD));
      drain_segments();
      set_image_size(0, 0);
      send_window(window(7, 4095, CA, CB, CC, CD));
   endtask

   task automatic test_random_windows(input int count, input int gap_pct, input int stall_pct,
                                      input int unsigned cols, input int unsigned rows);
      drain_segments();
      set_image_size(DIM_W'(cols), DIM_W'(rows));
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_window(random_window());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_triangle_classes();
      test_wrap_points();
      test_size_registers();
      test_random_windows(120, 23, 87, $urandom_range(1, 4096), $urandom_range(1, 4096));
      test_random_windows(120, 87, 23, 4096, $urandom_range(1, 64));
      test_random_windows(110, 0, 0, $urandom_range(1, 16), 8191);
      drain_segments();
      $display("Sent %0d windows and checked %0d segments under %0d image size settings,",
               windows_sent, segments_checked, size_settings);
      $display("with sender gaps and receiver stalls in both proportions and none.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: pixel_window_boundary_segments_top.f
design/pwbs_pkg.sv
design/pwbs_front.sv
design/pwbs_queue.sv
design/pwbs_back.sv
design/pixel_window_boundary_segments_top.sv
dv/testbench.sv
